>>> hw/rtl/hsvseg_pkg.sv
package hsvseg_pkg;

    localparam int unsigned PIX_W = 8;
    localparam int unsigned BND_W = 16;
    localparam int unsigned REG_COUNT = 5;
    localparam int unsigned IDX_W = 3;
    localparam logic [BND_W-1:0] BND_RESET = 16'hFF00;

    localparam logic [IDX_W-1:0] REG_HUE = 3'd0;
    localparam logic [IDX_W-1:0] REG_SAT = 3'd1;
    localparam logic [IDX_W-1:0] REG_VAL = 3'd2;
    localparam logic [IDX_W-1:0] REG_CR  = 3'd3;
    localparam logic [IDX_W-1:0] REG_CB  = 3'd4;

    typedef struct packed {
        logic [BND_W-1:0] hue;
        logic [BND_W-1:0] sat;
        logic [BND_W-1:0] val;
        logic [BND_W-1:0] cr;
        logic [BND_W-1:0] cb;
    } bounds_t;

    function automatic logic in_range(input logic [7:0] c, input logic [BND_W-1:0] b);
        return (c > b[7:0]) && (c <= b[15:8]);
    endfunction

    function automatic logic [7:0] clamp8(input logic signed [13:0] t);
        if (t < 0)
            return 8'd0;
        if (t > 14'sd255)
            return 8'd255;
        return t[7:0];
    endfunction

endpackage

>>> hw/rtl/hsvseg_cfg.sv
module hsvseg_cfg
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [hsvseg_pkg::IDX_W-1:0]       cfg_index,
    input  logic [hsvseg_pkg::BND_W-1:0]       cfg_data,
    output hsvseg_pkg::bounds_t                bounds
);

    hsvseg_pkg::bounds_t bounds_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bounds_reg <= '{hsvseg_pkg::BND_RESET, hsvseg_pkg::BND_RESET,
                            hsvseg_pkg::BND_RESET, hsvseg_pkg::BND_RESET,
                            hsvseg_pkg::BND_RESET};
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                hsvseg_pkg::REG_HUE: bounds_reg.hue <= cfg_data;
                hsvseg_pkg::REG_SAT: bounds_reg.sat <= cfg_data;
                hsvseg_pkg::REG_VAL: bounds_reg.val <= cfg_data;
                hsvseg_pkg::REG_CR:  bounds_reg.cr  <= cfg_data;
                hsvseg_pkg::REG_CB:  bounds_reg.cb  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign bounds = bounds_reg;

endmodule

>>> hw/rtl/hsvseg_pipe.sv
module hsvseg_pipe
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_valid,
    input  logic [7:0]          b_in,
    input  logic [7:0]          g_in,
    input  logic [7:0]          r_in,
    input  hsvseg_pkg::bounds_t bounds,
    output logic                out_valid,
    output logic [7:0]          b_out,
    output logic [7:0]          g_out,
    output logic [7:0]          r_out,
    output logic                sel_out
);

    // stage 1: max/min/delta, table lookups, luma products
    logic        v1_reg;
    logic [7:0]  b1_reg, g1_reg, r1_reg, mx1_reg, d1_reg;
    logic signed [11:0] h61_reg;
    logic [19:0] sd1_reg;
    logic [16:0] hd1_reg;
    logic [22:0] y1_reg;

    // stage 2: products
    logic        v2_reg;
    logic [7:0]  b2_reg, g2_reg, r2_reg, mx2_reg;
    logic [27:0] sp2_reg;
    logic signed [27:0] hp2_reg;
    logic [8:0]  y2_reg;

    // stage 3: rounding, chroma products
    logic        v3_reg;
    logic [7:0]  b3_reg, g3_reg, r3_reg, mx3_reg, s3_reg, h3_reg;
    logic signed [24:0] crp3_reg, cbp3_reg;

    // stage 4: tests
    logic        v4_reg, sel4_reg;
    logic [7:0]  b4_reg, g4_reg, r4_reg;

    logic [7:0] mx, mn, dd;
    logic signed [11:0] h6;
    logic signed [16:0] hsh;
    logic signed [9:0] hue_s;
    logic [7:0] hue;
    logic [7:0] cr, cb, sat;
    logic hpass;

    logic [19:0] sdiv_tbl [256];
    logic [16:0] hdiv_tbl [256];

    // reciprocal tables: round(255*4096/v) and round(122880/d), ties to even, 0 at index 0
    for (genvar gi = 0; gi < 256; gi++)
    begin : g_recip
        localparam int unsigned DEN = (gi == 0) ? 1 : gi;
        localparam int unsigned SQ  = 1044480 / DEN;
        localparam int unsigned SR  = 1044480 % DEN;
        localparam int unsigned HQ  = 122880 / DEN;
        localparam int unsigned HR  = 122880 % DEN;
        localparam int unsigned SV  = (gi == 0) ? 0
            : SQ + (((2 * SR > DEN) || ((2 * SR == DEN) && (SQ % 2 == 1))) ? 1 : 0);
        localparam int unsigned HV  = (gi == 0) ? 0
            : HQ + (((2 * HR > DEN) || ((2 * HR == DEN) && (HQ % 2 == 1))) ? 1 : 0);
        assign sdiv_tbl[gi] = 20'(SV);
        assign hdiv_tbl[gi] = 17'(HV);
    end

    always_comb
    begin
        mx = b_in;
        if (g_in > mx) mx = g_in;
        if (r_in > mx) mx = r_in;
        mn = b_in;
        if (g_in < mn) mn = g_in;
        if (r_in < mn) mn = r_in;
        dd = mx - mn;
        if (mx == r_in)
            h6 = $signed({4'b0, g_in}) - $signed({4'b0, b_in});
        else if (mx == g_in)
            h6 = $signed({4'b0, b_in}) - $signed({4'b0, r_in}) + $signed({3'b0, dd, 1'b0});
        else
            h6 = $signed({4'b0, r_in}) - $signed({4'b0, g_in}) + $signed({2'b0, dd, 2'b0});
    end

    always_comb
    begin
        hsh   = 17'((hp2_reg + 28'sd2048) >>> 12);
        hue_s = hsh[9:0];
        if (hue_s < 0)
            hue_s = hue_s + 10'sd180;
        hue   = hue_s[7:0];
        sat   = 8'((sp2_reg + 28'd2048) >> 12);
        cr    = hsvseg_pkg::clamp8(14'((crp3_reg + 25'sd8192) >>> 14));
        cb    = hsvseg_pkg::clamp8(14'((cbp3_reg + 25'sd8192) >>> 14));
        if (bounds.hue[7:0] < bounds.hue[15:8])
            hpass = (h3_reg > bounds.hue[7:0]) && (h3_reg <= bounds.hue[15:8]);
        else
            hpass = (h3_reg > bounds.hue[7:0]) || (h3_reg <= bounds.hue[15:8]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b1_reg  <= b_in;
            g1_reg  <= g_in;
            r1_reg  <= r_in;
            mx1_reg <= mx;
            d1_reg  <= dd;
            h61_reg <= h6;
            sd1_reg <= sdiv_tbl[mx];
            hd1_reg <= hdiv_tbl[dd];
            y1_reg  <= 23'(b_in * 12'd1868) + 23'(g_in * 14'd9617) + 23'(r_in * 13'd4899)
                       + 23'd8192;

            b2_reg  <= b1_reg;
            g2_reg  <= g1_reg;
            r2_reg  <= r1_reg;
            mx2_reg <= mx1_reg;
            sp2_reg <= 28'(d1_reg * sd1_reg);
            hp2_reg <= 28'(h61_reg * $signed({1'b0, hd1_reg}));
            y2_reg  <= y1_reg[22:14];

            b3_reg   <= b2_reg;
            g3_reg   <= g2_reg;
            r3_reg   <= r2_reg;
            mx3_reg  <= mx2_reg;
            s3_reg   <= sat;
            h3_reg   <= hue;
            crp3_reg <= 25'(($signed({2'b0, r2_reg}) - $signed({1'b0, y2_reg})) * 15'sd11682)
                        + 25'sd2097152;
            cbp3_reg <= 25'(($signed({2'b0, b2_reg}) - $signed({1'b0, y2_reg})) * 15'sd9241)
                        + 25'sd2097152;

            b4_reg   <= b3_reg;
            g4_reg   <= g3_reg;
            r4_reg   <= r3_reg;
            sel4_reg <= hpass && hsvseg_pkg::in_range(s3_reg, bounds.sat)
                        && hsvseg_pkg::in_range(mx3_reg, bounds.val)
                        && hsvseg_pkg::in_range(cr, bounds.cr)
                        && hsvseg_pkg::in_range(cb, bounds.cb);
        end
    end

    assign out_valid = v4_reg;
    assign sel_out   = sel4_reg;
    assign b_out     = sel4_reg ? b4_reg : 8'd0;
    assign g_out     = sel4_reg ? g4_reg : 8'd0;
    assign r_out     = sel4_reg ? r4_reg : 8'd0;

    property p_sel_black;
        @(posedge clk) disable iff (!rst_n)
        (v4_reg && !sel4_reg) |-> (b_out == 8'd0 && g_out == 8'd0 && r_out == 8'd0);
    endproperty
    a_sel_black: assert property (p_sel_black) else $error("rejected pixel not black");

    property p_hold;
        @(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(v4_reg) && $stable(sel4_reg);
    endproperty
    a_hold: assert property (p_hold) else $error("last stage changed while stalled");

    property p_hue_range;
        @(posedge clk) disable iff (!rst_n)
        v3_reg |-> h3_reg < 8'd180;
    endproperty
    a_hue_range: assert property (p_hue_range) else $error("hue out of range");

endmodule

>>> hw/rtl/hsv_ycrcb_color_segmenter.sv
// Color threshold segmenter: each BGR pixel is converted to HSV (hue 0..179) and YCrCb and
// tested against five lower<c<=upper windows (hue wraps when lower >= upper). Passing
// pixels go out unchanged with selected set, others go out black. One pixel per clock
// unless stalled, through a four-stage pipeline that stalls as a whole while m_tvalid is high and m_tready low.
module hsv_ycrcb_color_segmenter
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [23:0]                  s_tdata,   // blue_in, green_in, red_in
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [31:0]                  m_tdata,   // blue_out, green_out, red_out, selected, 0 pad
    input  logic                         cfg_we,
    input  logic [hsvseg_pkg::IDX_W-1:0] cfg_index,
    input  logic [hsvseg_pkg::BND_W-1:0] cfg_data
);

    hsvseg_pkg::bounds_t bounds;
    logic adv, sel;
    logic [7:0] b_o, g_o, r_o;

    assign adv      = m_tready || !m_tvalid;
    assign s_tready = adv;

    hsvseg_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .bounds   (bounds)
    );

    hsvseg_pipe u_pipe
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (s_tvalid),
        .b_in     (s_tdata[7:0]),
        .g_in     (s_tdata[15:8]),
        .r_in     (s_tdata[23:16]),
        .bounds   (bounds),
        .out_valid(m_tvalid),
        .b_out    (b_o),
        .g_out    (g_o),
        .r_out    (r_o),
        .sel_out  (sel)
    );

    assign m_tdata = {7'd0, sel, r_o, g_o, b_o};

endmodule
